@@ sv/ipv4fx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4fx_pkg
// Shared types and constants of the IPv4 flow header extractor.
// ----------------------------------------------------------------------------
package ipv4fx_pkg;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [6:0]  MIN_HDR_BYTES  = 7'd20;
	localparam logic [6:0]  OFFSET_MAX     = 7'd127;
	localparam logic [3:0]  IHL_MIN        = 4'd5;
	localparam logic [7:0]  PROTO_ICMP     = 8'd1;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [6:0]  PORT_BYTES     = 7'd4;

	// header byte offsets of the captured fields
	localparam logic [6:0]  OFF_IHL        = 7'd0;
	localparam logic [6:0]  OFF_PROTO      = 7'd9;
	localparam logic [6:0]  OFF_SRC_FIRST  = 7'd12;
	localparam logic [6:0]  OFF_SRC_LAST   = 7'd15;
	localparam logic [6:0]  OFF_DST_FIRST  = 7'd16;
	localparam logic [6:0]  OFF_DST_LAST   = 7'd19;

	localparam int REC_FIFO_DEPTH = 4;

	typedef enum logic [1:0] {
		ST_RECORD   = 2'd0,
		ST_DROPPED  = 2'd1,
		ST_FILTERED = 2'd2
	} status_t;

	// packet summary handed from the parser to the record builder
	typedef struct packed {
		logic        no_slot;
		logic        is_ipv4;
		logic [6:0]  seen;
		logic [3:0]  header_words;
		logic [7:0]  proto;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [15:0] length;
		logic [63:0] time_ns;
		logic [63:0] drops;
	} summary_t;

endpackage

@@ sv/ipv4fx_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4fx_front
// Byte parser: tracks the offset, captures header fields, emits a summary.
// ----------------------------------------------------------------------------
module ipv4fx_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 xfer,
	input  logic [7:0]           data_byte,
	input  logic                 first_byte,
	input  logic                 last_byte,
	input  logic [15:0]          ethertype,
	input  logic [15:0]          packet_length,
	input  logic                 space_available,
	input  logic [63:0]          time_ns,
	output logic                 sum_push,
	output ipv4fx_pkg::summary_t sum_data
);
	import ipv4fx_pkg::*;

	logic [6:0]  offset_q;
	logic [3:0]  hw_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [15:0] sport_q;
	logic [15:0] dport_q;
	logic [1:0]  flags_q;
	logic [15:0] len_q;
	logic [63:0] drops_q;

	logic [6:0]  off_b;
	logic [3:0]  hw_b, hw_n;
	logic [7:0]  proto_b, proto_n;
	logic [31:0] src_b, src_n;
	logic [31:0] dst_b, dst_n;
	logic [15:0] sport_b, sport_n;
	logic [15:0] dport_b, dport_n;
	logic [1:0]  flags_b;
	logic [15:0] len_b;
	logic [63:0] drops_b;
	logic [6:0]  hl;
	logic [6:0]  seen;

	always_comb begin
		// a first byte restarts the packet context
		off_b   = first_byte ? '0 : offset_q;
		hw_b    = first_byte ? '0 : hw_q;
		proto_b = first_byte ? '0 : proto_q;
		src_b   = first_byte ? '0 : src_q;
		dst_b   = first_byte ? '0 : dst_q;
		sport_b = first_byte ? '0 : sport_q;
		dport_b = first_byte ? '0 : dport_q;
		len_b   = first_byte ? packet_length : len_q;
		flags_b = first_byte ? {(ethertype == ETHERTYPE_IPV4), ~space_available} : flags_q;
		drops_b = drops_q + {63'd0, first_byte & ~space_available};

		hw_n    = (off_b == OFF_IHL) ? data_byte[3:0] : hw_b;
		proto_n = (off_b == OFF_PROTO) ? data_byte : proto_b;
		src_n   = (off_b >= OFF_SRC_FIRST && off_b <= OFF_SRC_LAST) ?
			{src_b[23:0], data_byte} : src_b;
		dst_n   = (off_b >= OFF_DST_FIRST && off_b <= OFF_DST_LAST) ?
			{dst_b[23:0], data_byte} : dst_b;
		hl      = {1'b0, hw_n, 2'b00};
		sport_n = (off_b == hl || off_b == hl + 7'd1) ? {sport_b[7:0], data_byte} : sport_b;
		dport_n = (off_b == hl + 7'd2 || off_b == hl + 7'd3) ?
			{dport_b[7:0], data_byte} : dport_b;
		seen    = (off_b == OFFSET_MAX) ? OFFSET_MAX : off_b + 7'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			hw_q     <= '0;
			proto_q  <= '0;
			src_q    <= '0;
			dst_q    <= '0;
			sport_q  <= '0;
			dport_q  <= '0;
			flags_q  <= '0;
			len_q    <= '0;
			drops_q  <= '0;
		end else if (xfer) begin
			hw_q    <= hw_n;
			proto_q <= proto_n;
			src_q   <= src_n;
			dst_q   <= dst_n;
			sport_q <= sport_n;
			dport_q <= dport_n;
			len_q   <= len_b;
			drops_q <= drops_b;
			// clear offset and flags at packet end
			offset_q <= last_byte ? '0 : seen;
			flags_q  <= last_byte ? '0 : flags_b;
		end
	end

	assign sum_push = xfer & last_byte;

	always_comb begin
		sum_data.no_slot      = flags_b[0];
		sum_data.is_ipv4      = flags_b[1];
		sum_data.seen         = seen;
		sum_data.header_words = hw_n;
		sum_data.proto        = proto_n;
		sum_data.src_addr     = src_n;
		sum_data.dst_addr     = dst_n;
		sum_data.sport        = sport_n;
		sum_data.dport        = dport_n;
		sum_data.length       = len_b;
		sum_data.time_ns      = time_ns;
		sum_data.drops        = drops_b;
	end

endmodule

@@ sv/ipv4fx_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4fx_fifo
// Small summary queue between the parser and the record builder.
// ----------------------------------------------------------------------------
module ipv4fx_fifo #(
	parameter int Depth = ipv4fx_pkg::REC_FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  ipv4fx_pkg::summary_t wr_data,
	output logic                 full,
	input  logic                 rd_en,
	output ipv4fx_pkg::summary_t rd_data,
	output logic                 empty
);
	import ipv4fx_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	summary_t            mem_q [Depth];
	logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                do_wr, do_rd;

	assign full  = (count_q == CntFull);
	assign empty = (count_q == '0);
	assign do_wr = wr_en & ~full;
	assign do_rd = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/ipv4fx_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4fx_back
// Record builder: judges a summary and holds the result for transfer.
// ----------------------------------------------------------------------------
module ipv4fx_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ipv4fx_pkg::summary_t sum_data,
	input  logic                 sum_valid,
	output logic                 sum_take,
	input  logic                 pop,
	output logic                 empty,
	output logic [1:0]           status,
	output logic [31:0]          source_address,
	output logic [31:0]          destination_address,
	output logic [15:0]          source_port,
	output logic [15:0]          destination_port,
	output logic [7:0]           ip_protocol,
	output logic [15:0]          record_length,
	output logic [63:0]          record_time,
	output logic [63:0]          drops_total
);
	import ipv4fx_pkg::*;

	logic        out_valid_q;
	status_t     status_q;
	logic [31:0] src_q, dst_q;
	logic [15:0] sport_q, dport_q, len_q;
	logic [7:0]  proto_q;
	logic [63:0] time_q, drops_q;

	status_t     st;
	logic        known_proto, is_icmp, ok;
	logic [6:0]  need;

	always_comb begin
		is_icmp     = (sum_data.proto == PROTO_ICMP);
		known_proto = is_icmp || sum_data.proto == PROTO_TCP || sum_data.proto == PROTO_UDP;
		need        = {1'b0, sum_data.header_words, 2'b00} + PORT_BYTES;
		if (sum_data.no_slot) begin
			st = ST_DROPPED;
		end else if (!sum_data.is_ipv4 || sum_data.seen < MIN_HDR_BYTES ||
		             sum_data.header_words < IHL_MIN || !known_proto) begin
			st = ST_FILTERED;
		end else if (!is_icmp && sum_data.seen < need) begin
			st = ST_FILTERED;
		end else begin
			st = ST_RECORD;
		end
		ok = (st == ST_RECORD);
	end

	// refill the output register when it is free or being drained
	assign sum_take = sum_valid & (~out_valid_q | pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sum_take) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_take) begin
			status_q <= st;
			src_q    <= ok ? sum_data.src_addr : '0;
			dst_q    <= ok ? sum_data.dst_addr : '0;
			sport_q  <= (ok && !is_icmp) ? sum_data.sport : '0;
			dport_q  <= (ok && !is_icmp) ? sum_data.dport : '0;
			proto_q  <= ok ? sum_data.proto : '0;
			len_q    <= ok ? sum_data.length : '0;
			time_q   <= ok ? sum_data.time_ns : '0;
			drops_q  <= sum_data.drops;
		end
	end

	assign empty               = ~out_valid_q;
	assign status              = status_q;
	assign source_address      = src_q;
	assign destination_address = dst_q;
	assign source_port         = sport_q;
	assign destination_port    = dport_q;
	assign ip_protocol         = proto_q;
	assign record_length       = len_q;
	assign record_time         = time_q;
	assign drops_total         = drops_q;

endmodule

@@ sv/ipv4_flow_header_extractor_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_flow_header_extractor_unit
// IPv4 five-tuple extractor: one packet byte in per cycle while full is
// low, one result out per packet.
// ----------------------------------------------------------------------------
// Feed a packet one byte per transfer, starting at the IPv4 header, with
// first_byte on its opening byte and last_byte on its final one. The unit
// takes one byte every cycle while full is low, and the last byte of a
// packet leaves one result: a record (status 0), a no-space drop
// (status 1) or a filtered notice (status 2), with the running drop
// count. A result passes the summary queue and then the output register
// before it reaches the result ports. Between the parser and the output
// register sits a queue of FifoDepth packet summaries, so the byte side
// keeps running while results wait to be popped; full rises only once
// that queue and the output register are all occupied. Every capture
// register of the parser, the offset and the drop counter clear on reset.
// ----------------------------------------------------------------------------
module ipv4_flow_header_extractor_unit #(
	parameter int FifoDepth = ipv4fx_pkg::REC_FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	input  logic [15:0] ethertype,
	input  logic [15:0] packet_length,
	input  logic        space_available,
	input  logic [63:0] time_ns,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [31:0] source_address,
	output logic [31:0] destination_address,
	output logic [15:0] source_port,
	output logic [15:0] destination_port,
	output logic [7:0]  ip_protocol,
	output logic [15:0] record_length,
	output logic [63:0] record_time,
	output logic [63:0] drops_total
);
	import ipv4fx_pkg::*;

	logic     in_xfer;
	logic     sum_push;
	summary_t sum_wr, sum_rd;
	logic     fifo_full, fifo_empty;
	logic     sum_take;

	// hold off new bytes while the summary queue cannot take a packet end
	assign full    = fifo_full;
	assign in_xfer = push & ~fifo_full;

	// front: parse bytes, emit a summary on each last byte
	ipv4fx_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.xfer           (in_xfer),
		.data_byte      (data_byte),
		.first_byte     (first_byte),
		.last_byte      (last_byte),
		.ethertype      (ethertype),
		.packet_length  (packet_length),
		.space_available(space_available),
		.time_ns        (time_ns),
		.sum_push       (sum_push),
		.sum_data       (sum_wr)
	);

	// decouple the two sides
	ipv4fx_fifo #(
		.Depth(FifoDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (sum_push),
		.wr_data(sum_wr),
		.full   (fifo_full),
		.rd_en  (sum_take),
		.rd_data(sum_rd),
		.empty  (fifo_empty)
	);

	// back: judge the packet and present the result
	ipv4fx_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.sum_data           (sum_rd),
		.sum_valid          (~fifo_empty),
		.sum_take           (sum_take),
		.pop                (pop),
		.empty              (empty),
		.status             (status),
		.source_address     (source_address),
		.destination_address(destination_address),
		.source_port        (source_port),
		.destination_port   (destination_port),
		.ip_protocol        (ip_protocol),
		.record_length      (record_length),
		.record_time        (record_time),
		.drops_total        (drops_total)
	);

endmodule
